// File: rtl/iu2x_pkg.sv
// Shared types and constants for the 2x linear image upscaler.
// Used by iu2x_emit and image_upscale_2x_linear; depends on nothing.
`default_nettype none

package iu2x_pkg;

   localparam int COORD_BITS     = 11;
   localparam int CFG_BITS       = 11;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SOURCE_ROWS = 1'b0,
      REG_SOURCE_COLS = 1'b1
   } iu2x_reg_type;

   // Output blocks in emission order for one source pixel
   typedef enum logic [1:0] {
      BLK_UP_LEFT  = 2'd0,
      BLK_UP_EDGE  = 2'd1,
      BLK_ROW_LEFT = 2'd2,
      BLK_ROW_EDGE = 2'd3
   } iu2x_blk_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
      logic                  row_zero;
      logic                  col_zero;
      logic                  last_row;
      logic                  last_col;
   } iu2x_pos_type;

endpackage

`default_nettype wire

// File: rtl/image_upscale_2x_linear.sv
// Top level of the 2x linear image upscaler: configuration, raster
// counters and the previous-row line buffer. Depends on iu2x_pkg,
// iu2x_ram and iu2x_emit.
//
// Source pixels enter in raster order; every pixel past the first row
// and the first column yields one 2x2 output block, plus an edge block
// at the last column and another on the last source row, values scaled
// by four. Results leave one word per cycle from a result register while
// the receiver is ready, and a receiver hold-off stalls them. A source
// pixel yields 4 words in steady state, none on the first source row or
// in the first column, 8 at the last column or on the last source row
// and 16 for the last pixel of the frame. The next pixel is taken in the
// cycle the previous one hands over its final result.
// The line buffer is read and rewritten at the same column for each
// accepted pixel and needs no clearing pass; the first source row of a
// frame fills it. A configuration write restarts the frame at pixel (0,0).
`default_nettype none

module image_upscale_2x_linear
   import iu2x_pkg::*;
#(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 1024,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // pixel
   input  wire logic [((PIXEL_BITS+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // out_row, out_col, out_value
   output logic [((2*COORD_BITS+PIXEL_BITS+2+7)/8)*8-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // frame_last
   output logic                           rsp_tuser,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_data
);

   localparam int OUT_DATA_BITS = ((2*COORD_BITS+PIXEL_BITS+2+7)/8)*8;
   localparam int VB            = PIXEL_BITS + 2;
   localparam int ROW_BITS      = $clog2(MAX_ROWS);
   localparam int COL_BITS      = $clog2(MAX_COLS);
   localparam int ROW_DIM_BITS  = $clog2(MAX_ROWS + 1);
   localparam int COL_DIM_BITS  = $clog2(MAX_COLS + 1);
   localparam int ROW_W = (ROW_DIM_BITS > CFG_BITS) ? ROW_DIM_BITS : CFG_BITS;
   localparam int COL_W = (COL_DIM_BITS > CFG_BITS) ? COL_DIM_BITS : CFG_BITS;
   localparam int RESET_ROWS = (1024 > MAX_ROWS) ? MAX_ROWS : 1024;
   localparam int RESET_COLS = (1024 > MAX_COLS) ? MAX_COLS : 1024;

   logic [ROW_BITS-1:0]   row_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic [ROW_W-1:0]      rows_eff_ff;
   logic [COL_W-1:0]      cols_eff_ff;
   logic [ROW_W-1:0]      rows_clamp;
   logic [COL_W-1:0]      cols_clamp;
   logic                  last_row;
   logic                  last_col;
   logic                  accept;
   logic                  csr_write;
   logic                  job_ready;
   iu2x_pos_type          pos;
   logic [PIXEL_BITS-1:0] pixel;
   logic [PIXEL_BITS-1:0] up_pixel;
   logic [COORD_BITS-1:0] out_row;
   logic [COORD_BITS-1:0] out_col;
   logic [VB-1:0]         out_value;

   assign pixel      = req_tdata[PIXEL_BITS-1:0];
   assign req_tready = job_ready;
   assign accept     = req_tvalid && job_ready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   always_comb begin
      if (csr_data < CFG_BITS'(2)) begin
         rows_clamp = ROW_W'(2);
      end else if (ROW_W'(csr_data) > ROW_W'(MAX_ROWS)) begin
         rows_clamp = ROW_W'(MAX_ROWS);
      end else begin
         rows_clamp = ROW_W'(csr_data);
      end
      if (csr_data < CFG_BITS'(2)) begin
         cols_clamp = COL_W'(2);
      end else if (COL_W'(csr_data) > COL_W'(MAX_COLS)) begin
         cols_clamp = COL_W'(MAX_COLS);
      end else begin
         cols_clamp = COL_W'(csr_data);
      end
   end

   assign last_row = (ROW_W'(row_ff) + ROW_W'(1)) >= rows_eff_ff;
   assign last_col = (COL_W'(col_ff) + COL_W'(1)) >= cols_eff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         rows_eff_ff <= ROW_W'(RESET_ROWS);
         cols_eff_ff <= COL_W'(RESET_COLS);
      end else if (csr_write) begin
         unique case (iu2x_reg_type'(csr_index))
            REG_SOURCE_ROWS: rows_eff_ff <= rows_clamp;
            REG_SOURCE_COLS: cols_eff_ff <= cols_clamp;
         endcase
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_ff <= col_ff + COL_BITS'(1);
         end
      end
   end

   always_comb begin
      pos.row      = COORD_BITS'(row_ff);
      pos.col      = COORD_BITS'(col_ff);
      pos.row_zero = (row_ff == '0);
      pos.col_zero = (col_ff == '0);
      pos.last_row = last_row;
      pos.last_col = last_col;
   end

   iu2x_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_COLS)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (pixel),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (up_pixel)
   );

   iu2x_emit #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .job_load       (accept),
      .job_pos        (pos),
      .job_pixel      (pixel),
      .up_pixel       (up_pixel),
      .job_ready      (job_ready),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_row        (out_row),
      .rsp_col        (out_col),
      .rsp_value      (out_value),
      .rsp_run_last   (rsp_tlast),
      .rsp_frame_last (rsp_tuser)
   );

   assign rsp_tdata = OUT_DATA_BITS'({out_value, out_col, out_row});

   a_frame_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end word without run end");

   a_run_ends_odd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> out_row[0] && out_col[0])
      else $error("run end word not at lower right of a block");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (row_ff == '0) && (col_ff == '0))
      else $error("register write did not restart the frame");

endmodule

`default_nettype wire

// File: rtl/iu2x_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module iu2x_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/iu2x_emit.sv
// Result sequencer: walks the 2x2 output blocks of one source pixel and
// fills the result register. Depends on iu2x_pkg.
`default_nettype none

module iu2x_emit
   import iu2x_pkg::*;
#(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    job_load,
   input  wire iu2x_pos_type            job_pos,
   input  wire logic [PIXEL_BITS-1:0]   job_pixel,
   input  wire logic [PIXEL_BITS-1:0]   up_pixel,
   output logic                         job_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [COORD_BITS-1:0]        rsp_row,
   output logic [COORD_BITS-1:0]        rsp_col,
   output logic [PIXEL_BITS+1:0]        rsp_value,
   output logic                         rsp_run_last,
   output logic                         rsp_frame_last
);

   localparam int VB = PIXEL_BITS + 2;

   logic                  job_valid_ff;
   logic [3:0]            mask_ff;
   iu2x_blk_type          blk_ff;
   logic [1:0]            sub_ff;
   iu2x_pos_type          pos_ff;
   logic [PIXEL_BITS-1:0] pix_ff;
   logic [PIXEL_BITS-1:0] left_ff;
   logic [PIXEL_BITS-1:0] ul_ff;

   logic                  out_valid_ff;
   logic [COORD_BITS-1:0] out_row_ff;
   logic [COORD_BITS-1:0] out_col_ff;
   logic [VB-1:0]         out_value_ff;
   logic                  out_run_ff;
   logic                  out_frame_ff;

   logic [3:0]            mask_in;
   iu2x_blk_type          first_blk_in;
   iu2x_blk_type          next_blk;
   logic                  later_found;
   logic                  out_free;
   logic                  emit;
   logic                  final_res;
   logic                  done;

   logic [PIXEL_BITS-1:0] a_pix, b_pix, d_pix, e_pix;
   logic                  right_ok, below_ok;
   logic [VB-1:0]         sum_ab, sum_ad, sum_all, value;
   logic [COORD_BITS-1:0] src_row, src_col;
   logic                  upper_blk, left_blk;

   always_comb begin
      mask_in[0] = !job_pos.row_zero && !job_pos.col_zero;
      mask_in[1] = !job_pos.row_zero && job_pos.last_col;
      mask_in[2] = job_pos.last_row && !job_pos.col_zero;
      mask_in[3] = job_pos.last_row && job_pos.last_col;
      first_blk_in = BLK_ROW_EDGE;
      for (int k = 3; k >= 0; k--) begin
         if (mask_in[k]) begin
            first_blk_in = iu2x_blk_type'(2'(k));
         end
      end
   end

   always_comb begin
      later_found = 1'b0;
      next_blk    = blk_ff;
      for (int k = 3; k >= 0; k--) begin
         if (mask_ff[k] && (2'(k) > blk_ff)) begin
            later_found = 1'b1;
            next_blk    = iu2x_blk_type'(2'(k));
         end
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign emit      = job_valid_ff && (|mask_ff) && out_free;
   assign final_res = (sub_ff == 2'd3) && !later_found;
   assign done      = job_valid_ff && (!(|mask_ff) || (emit && final_res));
   assign job_ready = !job_valid_ff || done;

   always_comb begin
      unique case (blk_ff)
         BLK_UP_LEFT: begin
            a_pix = ul_ff;    b_pix = up_pixel;
            d_pix = left_ff;  e_pix = pix_ff;
            right_ok = 1'b1;  below_ok = 1'b1;
         end
         BLK_UP_EDGE: begin
            a_pix = up_pixel; b_pix = '0;
            d_pix = pix_ff;   e_pix = '0;
            right_ok = 1'b0;  below_ok = 1'b1;
         end
         BLK_ROW_LEFT: begin
            a_pix = left_ff;  b_pix = pix_ff;
            d_pix = '0;       e_pix = '0;
            right_ok = 1'b1;  below_ok = 1'b0;
         end
         default: begin
            a_pix = pix_ff;   b_pix = '0;
            d_pix = '0;       e_pix = '0;
            right_ok = 1'b0;  below_ok = 1'b0;
         end
      endcase
   end

   assign sum_ab  = VB'(a_pix) + VB'(b_pix);
   assign sum_ad  = VB'(a_pix) + VB'(d_pix);
   assign sum_all = sum_ab + VB'(d_pix) + VB'(e_pix);

   always_comb begin
      case (sub_ff)
         2'd0:    value = {a_pix, 2'b00};
         2'd1:    value = right_ok ? (sum_ab << 1) : '0;
         2'd2:    value = below_ok ? (sum_ad << 1) : '0;
         default: value = (right_ok && below_ok) ? sum_all : '0;
      endcase
   end

   assign upper_blk = (blk_ff == BLK_UP_LEFT) || (blk_ff == BLK_UP_EDGE);
   assign left_blk  = (blk_ff == BLK_UP_LEFT) || (blk_ff == BLK_ROW_LEFT);
   assign src_row   = upper_blk ? (pos_ff.row - COORD_BITS'(1)) : pos_ff.row;
   assign src_col   = left_blk  ? (pos_ff.col - COORD_BITS'(1)) : pos_ff.col;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         mask_ff      <= '0;
         blk_ff       <= BLK_UP_LEFT;
         sub_ff       <= '0;
         left_ff      <= '0;
         ul_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_load) begin
            job_valid_ff <= 1'b1;
            mask_ff      <= mask_in;
            blk_ff       <= first_blk_in;
            sub_ff       <= '0;
         end else if (done) begin
            job_valid_ff <= 1'b0;
         end else if (emit) begin
            if (sub_ff == 2'd3) begin
               blk_ff <= next_blk;
               sub_ff <= '0;
            end else begin
               sub_ff <= sub_ff + 2'd1;
            end
         end
         if (done) begin
            left_ff <= pix_ff;
            ul_ff   <= up_pixel;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         pos_ff <= job_pos;
         pix_ff <= job_pixel;
      end
      if (emit) begin
         out_row_ff   <= {src_row[COORD_BITS-2:0], sub_ff[1]};
         out_col_ff   <= {src_col[COORD_BITS-2:0], sub_ff[0]};
         out_value_ff <= value;
         out_run_ff   <= final_res;
         out_frame_ff <= final_res && pos_ff.last_row && pos_ff.last_col;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_row        = out_row_ff;
   assign rsp_col        = out_col_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_run_last   = out_run_ff;
   assign rsp_frame_last = out_frame_ff;

endmodule

`default_nettype wire

// File: sim/image_upscale_2x_linear_test.sv
// Self-checking testbench for image_upscale_2x_linear: directed table, random frames,
// a stall phase and an oversized frame, each output word checked against a local predictor.
// Depends on iu2x_pkg and the image_upscale_2x_linear RTL.
`default_nettype none

module image_upscale_2x_linear_test;
   import iu2x_pkg::*;

   localparam int LINE_MAX  = 1024;
   localparam int RSP_BITS  = 40;
   localparam int IDLE_PCT  = 22;
   localparam int SETTLE    = 40;
   localparam int HOLD_OFF  = 300;
   localparam int DRAIN_MAX = 20000;

   typedef struct packed {
      logic [10:0] row;
      logic [10:0] col;
      logic [17:0] value;
      logic        run_last;
      logic        frame_last;
   } upscaled_word_type;

   typedef enum logic {DO_PIXEL, DO_CSR} stim_op_type;

   typedef struct packed {
      stim_op_type       op;
      iu2x_reg_type      idx;
      logic [15:0]       data;
      logic              typed;
      upscaled_word_type known;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   iu2x_reg_type        csr_index = REG_SOURCE_ROWS;
   logic [10:0]         csr_data = '0;

   // predictor state
   logic [15:0]       prev_line [LINE_MAX];
   logic [15:0]       left_px = '0;
   logic [15:0]       upleft_px = '0;
   int                row_pos = 0;
   int                col_pos = 0;
   logic [10:0]       rows_raw = 11'd1024;
   logic [10:0]       cols_raw = 11'd1024;
   upscaled_word_type step_words [16];
   int                step_count;
   upscaled_word_type upscaled_pixels [$];

   int errors = 0;
   bit no_idle = 1'b0;
   bit hold_rsp = 1'b0;

   stim_row_type directed [20] = '{
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hFFFF, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h0000, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h5A5A, 1'b0, '0},
      '{DO_CSR,   REG_SOURCE_ROWS, 16'd0,    1'b0, '0},
      '{DO_CSR,   REG_SOURCE_COLS, 16'd1,    1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hFFFF, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h0000, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h0000, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hFFFF, 1'b1, '{11'd0, 11'd0, 18'd262140, 1'b0, 1'b0}},
      '{DO_CSR,   REG_SOURCE_COLS, 16'd3,    1'b0, '0},
      '{DO_CSR,   REG_SOURCE_ROWS, 16'd3,    1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hFFFF, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h0001, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h8000, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h7FFF, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h0000, 1'b1, '{11'd0, 11'd0, 18'd262140, 1'b0, 1'b0}},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hFFFF, 1'b1, '{11'd0, 11'd2, 18'd4, 1'b0, 1'b0}},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hAAAA, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'h5555, 1'b0, '0},
      '{DO_PIXEL, REG_SOURCE_ROWS, 16'hFFFF, 1'b0, '0}
   };

   image_upscale_2x_linear dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      errors++;
      if (errors <= 40)
         $display("%0t mismatch: %s got %0d want %0d", $time, what, got_v, want_v);
   endtask

   function automatic int clamp_size(input logic [10:0] raw);
      if (raw < 11'd2) return 2;
      if (raw > 11'd1024) return 1024;
      return int'(raw);
   endfunction

   function automatic void add_word(input int row, input int col, input int value);
      step_words[step_count] = '{row: 11'(row), col: 11'(col), value: 18'(value),
                                 run_last: 1'b0, frame_last: 1'b0};
      step_count++;
   endfunction

   // a = S(j,i), b = S(j,i+1), d = S(j+1,i), e = S(j+1,i+1)
   function automatic void add_block(input int j, input int i, input int a, input int b,
                                     input int d, input int e, input bit right,
                                     input bit below);
      add_word(2*j,   2*i,   4*a);
      add_word(2*j,   2*i+1, right ? 2*(a+b) : 0);
      add_word(2*j+1, 2*i,   below ? 2*(a+d) : 0);
      add_word(2*j+1, 2*i+1, (right && below) ? a+b+d+e : 0);
   endfunction

   function automatic void upscale_pixel(input logic [15:0] px, input bit typed,
                                         input upscaled_word_type known);
      int rows_eff;
      int cols_eff;
      int up;
      bit last_col;
      bit last_row;
      rows_eff = clamp_size(rows_raw);
      cols_eff = clamp_size(cols_raw);
      up = int'(prev_line[col_pos]);
      last_col = (col_pos + 1 >= cols_eff);
      last_row = (row_pos + 1 >= rows_eff);
      step_count = 0;
      if (row_pos >= 1) begin
         if (col_pos >= 1)
            add_block(row_pos-1, col_pos-1, int'(upleft_px), up, int'(left_px), int'(px), 1, 1);
         if (last_col)
            add_block(row_pos-1, col_pos, up, 0, int'(px), 0, 0, 1);
      end
      if (last_row) begin
         if (col_pos >= 1)
            add_block(row_pos, col_pos-1, int'(left_px), int'(px), 0, 0, 1, 0);
         if (last_col)
            add_block(row_pos, col_pos, int'(px), 0, 0, 0, 0, 0);
      end
      if (step_count > 0) begin
         step_words[step_count-1].run_last = 1'b1;
         step_words[step_count-1].frame_last = last_row && last_col;
         if (typed) begin
            step_words[0].row = known.row;
            step_words[0].col = known.col;
            step_words[0].value = known.value;
         end
      end
      for (int k = 0; k < step_count; k++)
         upscaled_pixels = {upscaled_pixels, step_words[k]};
      prev_line[col_pos] = px;
      upleft_px = 16'(up);
      left_px = px;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endfunction

   // call at a falling edge; returns at a falling edge
   task automatic send_pixel(input logic [15:0] px, input bit typed = 1'b0,
                             input upscaled_word_type known = '0);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      upscale_pixel(px, typed, known);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (upscaled_pixels.size() != 0 && waited < DRAIN_MAX) begin
         @(negedge clock);
         waited++;
      end
      if (upscaled_pixels.size() != 0) begin
         report_mismatch("words never delivered", upscaled_pixels.size(), 0);
         upscaled_pixels.delete();
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input iu2x_reg_type idx, input logic [10:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SOURCE_ROWS) rows_raw = val;
      else cols_raw = val;
      row_pos = 0;
      col_pos = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [10:0] random_size(input int top);
      if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 1));
      return 11'($urandom_range(2, top));
   endfunction

   // receiver: random stalls, one long hold-off on request
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            held = 1'b1;
         end
         rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      upscaled_word_type got;
      upscaled_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[10:0], rsp_tdata[21:11], rsp_tdata[39:22], rsp_tlast, rsp_tuser};
         if (upscaled_pixels.size() == 0) begin
            report_mismatch("word with nothing pending, value", int'(got.value), -1);
         end else begin
            want = upscaled_pixels.pop_front();
            if (got.row !== want.row)
               report_mismatch("out_row", int'(got.row), int'(want.row));
            if (got.col !== want.col)
               report_mismatch("out_col", int'(got.col), int'(want.col));
            if (got.value !== want.value)
               report_mismatch("out_value", int'(got.value), int'(want.value));
            if (got.run_last !== want.run_last)
               report_mismatch("run_last", int'(got.run_last), int'(want.run_last));
            if (got.frame_last !== want.frame_last)
               report_mismatch("frame_last", int'(got.frame_last), int'(want.frame_last));
         end
      end
   end

   initial begin
      int random_items;
      int frame_px;
      logic [10:0] rows_w;
      logic [10:0] cols_w;
      random_items = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[k]) begin
         if (directed[k].op == DO_CSR)
            write_reg(directed[k].idx, directed[k].data[10:0]);
         else
            send_pixel(directed[k].data, directed[k].typed, directed[k].known);
      end

      // small frames, some cut short by a restart
      while (random_items < 50) begin
         rows_w = random_size(4);
         cols_w = random_size(5);
         if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_SOURCE_ROWS, rows_w);
            write_reg(REG_SOURCE_COLS, cols_w);
         end else begin
            write_reg(REG_SOURCE_COLS, cols_w);
            write_reg(REG_SOURCE_ROWS, rows_w);
         end
         frame_px = clamp_size(rows_w) * clamp_size(cols_w) * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0) frame_px = $urandom_range(1, frame_px - 1);
         repeat (frame_px) begin
            send_pixel(random_pixel());
            random_items++;
         end
      end

      // long receiver hold-off, then a full pause of the sender
      write_reg(REG_SOURCE_ROWS, 11'd3);
      write_reg(REG_SOURCE_COLS, 11'd4);
      for (int k = 0; k < 12; k++) begin
         if (k == 5) hold_rsp = 1'b1;
         if (k == 9) wait_drained();
         send_pixel(random_pixel());
      end

      // oversized register value, no idling on either side
      write_reg(REG_SOURCE_COLS, 11'd2);
      write_reg(REG_SOURCE_ROWS, 11'd2047);
      no_idle = 1'b1;
      repeat (20) send_pixel(random_pixel());
      no_idle = 1'b0;

      wait_drained();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
